// File: rtl/core/graphics_terminal_with_joystick_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the graphics terminal checker
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef GRAPHICS_TERMINAL_WITH_JOYSTICK_TOP_MACROS_SVH
`define GRAPHICS_TERMINAL_WITH_JOYSTICK_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GTJ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graphics terminal check failed");

// next-cycle implication, disabled in reset
`define GTJ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graphics terminal check failed");

`endif

// File: rtl/core/gtj_pkg.sv
// ----------------------------------------------------------------------------
// gtj_pkg
// Shared widths, codes and control types for the graphics terminal.
// ----------------------------------------------------------------------------
package gtj_pkg;

	localparam int SCREEN_WIDTH_DEF  = 64;
	localparam int SCREEN_HEIGHT_DEF = 96;

	localparam int MODE_W = 3;
	localparam int DATA_W = 8;
	localparam int KEY_W  = 3;
	localparam int SX_W   = 6;
	localparam int SY_W   = 7;
	localparam int STEP_W = 7;
	localparam int X_W    = 6;
	localparam int Y_W    = 7;
	localparam int LATCH_W = 7;
	localparam int SUM_W  = 9;

	// bus operations
	localparam logic [MODE_W-1:0] MODE_DISP_WR  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DISP_RD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_JOY_DATA = 3'd2;
	localparam logic [MODE_W-1:0] MODE_JOY_STAT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_JOY_CTL  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_KEY      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SCAN     = 3'd6;

	// key events
	localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd0;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP     = 3'd2;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd3;
	localparam logic [KEY_W-1:0] KEY_CENTRE = 3'd4;

	// display control commands
	localparam logic [2:0] CTL_PREFIX = 3'b111;
	localparam logic [2:0] CTL_INVERT = 3'd0;
	localparam logic [2:0] CTL_NORMAL = 3'd1;
	localparam logic [2:0] CTL_BLANK  = 3'd4;
	localparam logic [2:0] CTL_SHOW   = 3'd5;

	localparam logic [DATA_W-1:0] DISP_RD_VALUE  = 8'hFF;
	localparam logic [DATA_W-1:0] JOY_STAT_VALUE = 8'h80;
	localparam logic [STEP_W-1:0] DEFAULT_STEP   = 7'd3;

	typedef struct packed {
		logic clear;
		logic exec;
	} gtj_cmd_t;

	typedef struct packed {
		logic clear_last;
	} gtj_sts_t;

endpackage

// File: rtl/core/gtj_ctrl.sv
// ----------------------------------------------------------------------------
// gtj_ctrl
// Controller: bitmap clearing pass after reset, then one command per cycle.
// ----------------------------------------------------------------------------
module gtj_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gtj_pkg::gtj_sts_t sts,
	output gtj_pkg::gtj_cmd_t cmd,
	output logic            busy,
	output logic            done
);
	import gtj_pkg::*;

	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_RUN   = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				state_d = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy      = (state_q == ST_CLEAR);
	assign cmd.clear = busy;
	assign cmd.exec  = start & ~busy;
	assign done      = done_q;

endmodule

// File: rtl/core/gtj_datapath.sv
// ----------------------------------------------------------------------------
// gtj_datapath
// Bitmap memory, display flags, holding latch, joystick position and result
// registers.
// ----------------------------------------------------------------------------
module gtj_datapath #(
	parameter int SCREEN_WIDTH  = gtj_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gtj_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gtj_pkg::gtj_cmd_t           cmd,
	output gtj_pkg::gtj_sts_t           sts,
	input  logic                        cfg_we,
	input  logic [gtj_pkg::STEP_W-1:0]  cfg_data,
	input  logic [gtj_pkg::MODE_W-1:0]  mode,
	input  logic [gtj_pkg::DATA_W-1:0]  bus_data,
	input  logic [gtj_pkg::KEY_W-1:0]   key_code,
	input  logic [gtj_pkg::SX_W-1:0]    scan_x,
	input  logic [gtj_pkg::SY_W-1:0]    scan_y,
	output logic [gtj_pkg::DATA_W-1:0]  read_data,
	output logic                        scan_pixel
);
	import gtj_pkg::*;

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic signed [SUM_W-1:0] X_MAX = SUM_W'(SCREEN_WIDTH - 1);
	localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'(SCREEN_HEIGHT - 1);
	localparam logic signed [SUM_W-1:0] X_MID = SUM_W'(SCREEN_WIDTH / 2);
	localparam logic signed [SUM_W-1:0] Y_MID = SUM_W'(SCREEN_HEIGHT / 2);

	// bitmap
	logic          mem [DEPTH];
	logic          mem_we;
	logic          mem_wdata;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic          mem_rd_s1;
	logic [AW-1:0] clr_cnt_q;

	// architectural state
	logic [LATCH_W-1:0] latch_q, latch_d;
	logic               inv_q, inv_d;
	logic               blank_q, blank_d;
	logic               phase_q, phase_d;
	logic [X_W-1:0]     stick_x_q, x_new;
	logic [Y_W-1:0]     stick_y_q, y_new;
	logic [STEP_W-1:0]  step_q, step_eff;

	// results
	logic [DATA_W-1:0] rd_d, rd_s1;
	logic              pix_base_d, pix_base_s1;
	logic              pix_sel_d, pix_sel_s1;

	logic              pix_we;
	logic              key_en;
	logic              wr_on;
	logic              scan_on;
	logic [SY_W-1:0]   wr_y;
	logic signed [SUM_W-1:0] sx, sy, st, nx, ny;

	assign wr_y    = bus_data[SY_W-1:0];
	assign wr_on   = (int'(latch_q[X_W-1:0]) < SCREEN_WIDTH) && (int'(wr_y) < SCREEN_HEIGHT);
	assign scan_on = (int'(scan_x) < SCREEN_WIDTH) && (int'(scan_y) < SCREEN_HEIGHT);

	// operation decode
	always_comb begin
		latch_d    = latch_q;
		inv_d      = inv_q;
		blank_d    = blank_q;
		phase_d    = phase_q;
		pix_we     = 1'b0;
		key_en     = 1'b0;
		rd_d       = '0;
		pix_base_d = 1'b0;
		pix_sel_d  = 1'b0;
		unique case (mode)
			MODE_DISP_WR: begin
				if (!bus_data[7]) begin
					latch_d = bus_data[LATCH_W-1:0];
				end else if (bus_data[7:5] == CTL_PREFIX) begin
					case (bus_data[2:0])
						CTL_INVERT: inv_d   = 1'b1;
						CTL_NORMAL: inv_d   = 1'b0;
						CTL_BLANK:  blank_d = 1'b1;
						CTL_SHOW:   blank_d = 1'b0;
						default: begin
						end
					endcase
				end else begin
					pix_we = wr_on;
				end
			end
			MODE_DISP_RD: begin
				rd_d = DISP_RD_VALUE;
			end
			MODE_JOY_DATA: begin
				if (!phase_q) begin
					rd_d = {1'b1, 7'(stick_x_q)};
				end else begin
					rd_d = {1'b0, stick_y_q};
				end
				phase_d = ~phase_q;
			end
			MODE_JOY_STAT: begin
				rd_d = JOY_STAT_VALUE;
			end
			MODE_JOY_CTL: begin
				phase_d = 1'b0;
			end
			MODE_KEY: begin
				key_en = 1'b1;
			end
			MODE_SCAN: begin
				// blanked or off screen shows the background colour
				pix_base_d = inv_q;
				pix_sel_d  = ~blank_q & scan_on;
			end
			default: begin
			end
		endcase
	end

	// joystick movement: step in full, then saturate each axis
	assign step_eff = (step_q == '0) ? DEFAULT_STEP : step_q;
	assign sx = $signed({3'b000, stick_x_q});
	assign sy = $signed({2'b00, stick_y_q});
	assign st = $signed({2'b00, step_eff});

	always_comb begin
		nx = sx;
		ny = sy;
		case (key_code)
			KEY_LEFT:   nx = sx - st;
			KEY_RIGHT:  nx = sx + st;
			KEY_UP:     ny = sy - st;
			KEY_DOWN:   ny = sy + st;
			KEY_CENTRE: begin
				nx = X_MID;
				ny = Y_MID;
			end
			default: begin
			end
		endcase
		if (nx[SUM_W-1]) begin
			x_new = '0;
		end else if (nx > X_MAX) begin
			x_new = X_MAX[X_W-1:0];
		end else begin
			x_new = nx[X_W-1:0];
		end
		if (ny[SUM_W-1]) begin
			y_new = '0;
		end else if (ny > Y_MAX) begin
			y_new = Y_MAX[Y_W-1:0];
		end else begin
			y_new = ny[Y_W-1:0];
		end
	end

	// memory port: clearing pass takes priority, no command runs meanwhile
	assign mem_we    = cmd.clear | (cmd.exec & pix_we);
	assign mem_wdata = cmd.clear ? 1'b0 : latch_q[LATCH_W-1];
	assign mem_waddr = cmd.clear ? clr_cnt_q
		: AW'(int'(wr_y) * SCREEN_WIDTH + int'(latch_q[X_W-1:0]));
	assign mem_raddr = AW'(int'(scan_y) * SCREEN_WIDTH + int'(scan_x));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			latch_q   <= '0;
			inv_q     <= 1'b0;
			blank_q   <= 1'b0;
			phase_q   <= 1'b0;
			stick_x_q <= X_MID[X_W-1:0];
			stick_y_q <= Y_MID[Y_W-1:0];
			step_q    <= '0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			if (cmd.exec) begin
				latch_q <= latch_d;
				inv_q   <= inv_d;
				blank_q <= blank_d;
				phase_q <= phase_d;
				if (key_en) begin
					stick_x_q <= x_new;
					stick_y_q <= y_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_s1       <= rd_d;
			pix_base_s1 <= pix_base_d;
			pix_sel_s1  <= pix_sel_d;
		end
	end

	assign sts.clear_last = (clr_cnt_q == LAST_ADDR);
	assign read_data      = rd_s1;
	assign scan_pixel     = pix_base_s1 ^ (pix_sel_s1 & mem_rd_s1);

endmodule

// File: rtl/core/graphics_terminal_with_joystick_top.sv
// ----------------------------------------------------------------------------
// graphics_terminal_with_joystick_top
// One-bit bitmap terminal with joystick position register.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  command   | start / busy           | mode, bus_data, key_code, scan_x, scan_y
//  result    | done (one-cycle pulse) | read_data, scan_pixel
//  config    | cfg_valid / cfg_ready  | cfg_data (joystick step)
//
// One command per cycle once busy is low; its result appears on the cycle after acceptance.
// A scan uses the bitmap's own read port, beside the write port; read data is registered.
// After reset busy stays high while the bitmap is cleared one pixel a cycle;
// config writes are taken meanwhile.
// Results cannot be held off: each is valid for the single done cycle.
// ----------------------------------------------------------------------------
module graphics_terminal_with_joystick_top #(
	parameter int SCREEN_WIDTH  = gtj_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gtj_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gtj_pkg::MODE_W-1:0]  mode,
	input  logic [gtj_pkg::DATA_W-1:0]  bus_data,
	input  logic [gtj_pkg::KEY_W-1:0]   key_code,
	input  logic [gtj_pkg::SX_W-1:0]    scan_x,
	input  logic [gtj_pkg::SY_W-1:0]    scan_y,
	output logic                        done,
	output logic [gtj_pkg::DATA_W-1:0]  read_data,
	output logic                        scan_pixel,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gtj_pkg::STEP_W-1:0]  cfg_data
);
	import gtj_pkg::*;

	gtj_cmd_t cmd;
	gtj_sts_t sts;

	assign cfg_ready = 1'b1;

	gtj_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gtj_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.bus_data   (bus_data),
		.key_code   (key_code),
		.scan_x     (scan_x),
		.scan_y     (scan_y),
		.read_data  (read_data),
		.scan_pixel (scan_pixel)
	);

endmodule

// File: rtl/core/gtj_checker.sv
// ----------------------------------------------------------------------------
// gtj_checker
// Port-level checks on command and result timing and on result values, bound to the top level.
// ----------------------------------------------------------------------------
`include "graphics_terminal_with_joystick_top_macros.svh"

module gtj_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [gtj_pkg::MODE_W-1:0]  mode,
	input logic                        done,
	input logic [gtj_pkg::DATA_W-1:0]  read_data,
	input logic                        scan_pixel
);
	import gtj_pkg::*;

	// every accepted transaction yields exactly one result, in the next cycle
	`GTJ_ASSERT_NEXT(a_result_follows, start && !busy, done)
	`GTJ_ASSERT_SAME(a_no_spurious_result, done, $past(start && !busy))
	// only a scan drives the pixel output
	`GTJ_ASSERT_SAME(a_pixel_only_scan, done && ($past(mode) != MODE_SCAN), !scan_pixel)
	// display read returns all ones
	`GTJ_ASSERT_SAME(a_disp_read_value, done && ($past(mode) == MODE_DISP_RD),
		read_data == DISP_RD_VALUE)

endmodule

bind graphics_terminal_with_joystick_top gtj_checker u_gtj_checker (.*);
